FILE: rtl/core/cdws_pkg.sv
// Shared types, constants and fixed-point helpers for the channel diffusion walk step core.
// No dependencies; used by cdws_front, cdws_back and the top-level core.
`default_nettype none
package cdws_pkg;

  localparam int unsigned MOLECULES_DEF = 1024;
  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [3:0] {
    REG_BOX   = 4'd0,
    REG_CAP   = 4'd1,
    REG_CHAN  = 4'd2,
    REG_VEST  = 4'd3,
    REG_VBOT  = 4'd4,
    REG_DAB   = 4'd5,
    REG_DC    = 4'd6,
    REG_MICRO = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CL_WALK,
    CL_PLACE,
    CL_SKIP
  } item_class_e;

  typedef struct packed {
    item_class_e cls;
    logic [9:0]  molecule;
    logic [18:0] step_mag;
    logic [2:0]  direction;
    logic        edge_coin;
    logic [15:0] ua;
    logic [15:0] ub;
    logic [15:0] uc;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [30:0] box;
    logic [63:0] cap;
    logic [63:0] chan;
    logic [63:0] vest;
    logic [63:0] vbot;
    logic [63:0] dab;
    logic [63:0] dc;
    logic [9:0]  micro;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // (2u - 1) * S rounded toward zero
  function automatic logic signed [31:0] centred(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p[65] ? p + 66'sd65535 : p;
    return t[47:16];
  endfunction

  function automatic logic signed [31:0] height(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p >>> 16;
    return sat32(68'(t));
  endfunction

  function automatic logic open_rgn(input cfg_t c, input logic signed [31:0] z,
                                    input logic [65:0] r2);
    logic ok;
    ok = 1'b0;
    if (z > $signed(c.cap[31:0])) ok = 1'b1;
    if (z >= 0 && r2 >= 66'({c.cap[63:32], 16'b0})) ok = 1'b1;
    if (z <= $signed(c.vest[31:0]) && z >= $signed(c.vbot[31:0]) &&
        r2 <= 66'({c.vest[63:32], 16'b0})) ok = 1'b1;
    if (r2 <= 66'({c.chan[63:32], 16'b0})) ok = 1'b1;
    return ok;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cdws_front.sv
// Front end: accepts items, classifies them, and holds them in a two-entry queue.
// Depends on cdws_pkg.
`default_nettype none
module cdws_front #(
  parameter int unsigned MOLECULES = cdws_pkg::MOLECULES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                kind_i,
  input  wire logic [9:0]          molecule_i,
  input  wire logic [18:0]         step_mag_i,
  input  wire logic [2:0]          direction_i,
  input  wire logic                edge_coin_i,
  input  wire logic [15:0]         uniform_a_i,
  input  wire logic [15:0]         uniform_b_i,
  input  wire logic [15:0]         uniform_c_i,
  output cdws_pkg::queue_head_t    head_o,
  input  wire logic                pop_i
);

  cdws_pkg::item_t q_mem [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push;
  cdws_pkg::item_t new_item;

  always_comb begin
    new_item.molecule  = molecule_i;
    new_item.step_mag  = step_mag_i;
    new_item.direction = direction_i;
    new_item.edge_coin = edge_coin_i;
    new_item.ua        = uniform_a_i;
    new_item.ub        = uniform_b_i;
    new_item.uc        = uniform_c_i;
    if (17'(molecule_i) >= 17'(MOLECULES)) begin
      new_item.cls = cdws_pkg::CL_SKIP;
    end else if (kind_i) begin
      new_item.cls = cdws_pkg::CL_PLACE;
    end else begin
      new_item.cls = cdws_pkg::CL_WALK;
    end
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= new_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cdws_sqrt.sv
// Bit-serial integer square root, one result bit per cycle, 64-bit radicand.
// No package dependencies.
`default_nettype none
module cdws_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [63:0] n_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [34:0] rem_sh, trial, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q[32:0], n_q[63:62]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;
  assign done_o  = done_q;
  assign root_o  = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      root_q <= '0;
      n_q    <= rad_i;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sub : rem_sh;
      root_q <= {root_q[30:0], ge};
      n_q    <= {n_q[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cdws_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor,
// quotient known to fit in 32 bits. No package dependencies.
`default_nettype none
module cdws_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);

  logic [31:0] rem_q, lo_q, dv_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem2, diff;
  logic        ge;

  assign rem2   = {rem_q, lo_q[31]};
  assign diff   = rem2 - {1'b0, dv_q};
  assign ge     = rem2 >= {1'b0, dv_q};
  assign done_o = done_q;
  assign quot_o = lo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[63:32];
      lo_q  <= dividend_i[31:0];
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : rem2[31:0];
      lo_q  <= {lo_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cdws_back.sv
// Back end: sequencer with shared multiplier, molecule state memories, root and divide units,
// and the result register. Depends on cdws_pkg, cdws_sqrt, cdws_div.
`default_nettype none
module cdws_back #(
  parameter int unsigned MOLECULES = cdws_pkg::MOLECULES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  cdws_pkg::cfg_t             cfg_i,
  input  cdws_pkg::queue_head_t      head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       hit_o,
  output logic                       step_done_o,
  output logic                       micro_mode_o,
  output logic [31:0]                total_hits_o
);

  localparam int unsigned AW = (MOLECULES > 1) ? $clog2(MOLECULES) : 1;

  localparam logic [2:0] DIR_XP = 3'd0;
  localparam logic [2:0] DIR_XN = 3'd1;
  localparam logic [2:0] DIR_YP = 3'd2;
  localparam logic [2:0] DIR_YN = 3'd3;
  localparam logic [2:0] DIR_ZP = 3'd4;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_SQ1, S_SQ2, S_SQ3, S_STEP, S_CAND, S_OR1, S_OR2, S_OR3,
    S_ZONE, S_A1, S_A2, S_A3, S_ROOT, S_AMUL, S_DSTART, S_DWAIT, S_AFIN,
    S_XY1, S_XY2, S_XY3, S_FIN, S_R1, S_R2, S_R3,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_WB
  } state_e;

  state_e              state_q;
  cdws_pkg::item_t     it_q;
  logic signed [31:0]  x_q, y_q, z_q, tx_q, ty_q, tz_q;
  logic [9:0]          ml_q;
  logic                mf_q, zb_q, neg_q, hit_q, done_q;
  logic [65:0]         acc_q, xy2_q;
  logic [34:0]         step_q;
  logic signed [32:0]  zr_q, dx_q, dy_q, dz_q;
  logic [31:0]         r_q, hit_total_q;
  logic [1:0]          crd_q;
  logic [AW-1:0]       clr_q;
  logic signed [65:0]  prod_q;
  logic                out_valid_q, out_hit_q, out_done_q, out_micro_q;
  logic [31:0]         out_total_q;

  logic [95:0]         pos_mem [MOLECULES];
  logic [10:0]         meta_mem [MOLECULES];
  logic [95:0]         pos_rd_q;
  logic [10:0]         meta_rd_q;

  logic signed [33:0]  ma, mb;
  logic signed [67:0]  prod_full;
  logic [65:0]         sum_now;
  logic signed [31:0]  cap_h, v_bot, s_pos, neg_s32;
  logic signed [32:0]  neg_s;
  logic signed [33:0]  s2;
  logic [65:0]         ch_r2, cap_r2;
  logic signed [17:0]  cu_a, cu_b;
  logic signed [36:0]  step_s;
  logic [9:0]          mm;
  logic                wall_ok, open_ok, hit_now, out_free, micro_now;
  logic                pos_we, meta_we;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [16:0]         it_mol, hd_mol;
  logic [10:0]         meta_wdata;
  logic                sq_start, sq_done, div_start, div_done;
  logic [31:0]         sq_root, div_q;
  logic [65:0]         prod_abs;
  logic signed [32:0]  d_new;
  logic signed [31:0]  nx, ny, nz;
  logic signed [31:0]  cent_now, hgt_now;

  assign cap_h   = $signed(cfg_i.cap[31:0]);
  assign v_bot   = $signed(cfg_i.vbot[31:0]);
  assign s_pos   = $signed({1'b0, cfg_i.box});
  assign neg_s   = -$signed({2'b0, cfg_i.box});
  assign neg_s32 = neg_s[31:0];
  assign s2      = $signed({2'b0, cfg_i.box, 1'b0});
  assign ch_r2   = 66'({cfg_i.chan[63:32], 16'b0});
  assign cap_r2  = 66'({cfg_i.cap[63:32], 16'b0});
  assign cu_a    = $signed({1'b0, it_q.ua, 1'b0}) - 18'sd65536;
  assign cu_b    = $signed({1'b0, it_q.ub, 1'b0}) - 18'sd65536;
  assign step_s  = $signed({2'b0, step_q});
  assign mm      = (cfg_i.micro == 10'd0) ? 10'd1 : cfg_i.micro;
  assign sum_now = acc_q + $unsigned(prod_q);
  assign micro_now = sum_now <= 66'h1_0000_0000;
  assign prod_full = ma * mb;
  assign open_ok = cdws_pkg::open_rgn(cfg_i, tz_q, sum_now);
  assign hit_now = (z_q <= $signed(cfg_i.chan[31:0])) && (xy2_q <= ch_r2);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o   = (state_q == S_IDLE) && head_i.valid;
  assign it_mol  = 17'(it_q.molecule);
  assign hd_mol  = 17'(head_i.item.molecule);
  assign rd_addr = hd_mol[AW-1:0];
  assign prod_abs = prod_q[65] ? $unsigned(-prod_q) : $unsigned(prod_q);
  assign d_new   = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign nx      = cdws_pkg::sat32(68'(x_q) + 68'(dx_q));
  assign ny      = cdws_pkg::sat32(68'(y_q) + 68'(dy_q));
  assign nz      = cdws_pkg::sat32(68'(z_q) + 68'(dz_q));
  assign cent_now = cdws_pkg::centred(prod_q);
  assign hgt_now  = cdws_pkg::height(prod_q);
  assign sq_start  = (state_q == S_A3) && (sum_now[65:64] == 2'b00);
  assign div_start = (state_q == S_DSTART);

  always_comb begin
    case (it_q.direction)
      DIR_XP:  wall_ok = tx_q < s_pos;
      DIR_XN:  wall_ok = $signed({tx_q[31], tx_q}) > neg_s;
      DIR_YP:  wall_ok = ty_q < s_pos;
      DIR_YN:  wall_ok = $signed({ty_q[31], ty_q}) > neg_s;
      DIR_ZP:  wall_ok = $signed({tz_q[31], tz_q[31], tz_q}) < s2;
      default: wall_ok = 1'b1;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_LOAD: begin
        ma = 34'($signed(pos_rd_q[95:64]));
        mb = 34'($signed(pos_rd_q[95:64]));
      end
      S_SQ1, S_A1, S_XY2, S_P5: begin
        ma = 34'(y_q);
        mb = 34'(y_q);
      end
      S_SQ2: begin
        ma = 34'(z_q);
        mb = 34'(z_q);
      end
      S_SQ3: begin
        ma = $signed({15'b0, it_q.step_mag});
        mb = $signed({2'b0, cfg_i.dc[31:0]});
      end
      S_OR1: begin
        ma = 34'(tx_q);
        mb = 34'(tx_q);
      end
      S_OR2: begin
        ma = 34'(ty_q);
        mb = 34'(ty_q);
      end
      S_ZONE, S_XY1, S_P4: begin
        ma = 34'(x_q);
        mb = 34'(x_q);
      end
      S_A2: begin
        ma = 34'(zr_q);
        mb = 34'(zr_q);
      end
      S_AMUL: begin
        case (crd_q)
          2'd0:    ma = 34'(x_q);
          2'd1:    ma = 34'(y_q);
          default: ma = 34'(zr_q);
        endcase
        mb = 34'($signed(cfg_i.dab[31:0]));
      end
      S_R1, S_P1: begin
        ma = 34'(cu_a);
        mb = $signed({3'b0, cfg_i.box});
      end
      S_P2: begin
        ma = 34'(cu_b);
        mb = $signed({3'b0, cfg_i.box});
      end
      S_R2: begin
        ma = $signed({18'b0, it_q.ub});
        mb = s2;
      end
      S_P3: begin
        ma = $signed({18'b0, it_q.uc});
        mb = s2;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    pos_we     = (state_q == S_WB) && out_free && (it_q.cls != cdws_pkg::CL_SKIP);
    meta_we    = pos_we || (state_q == S_CLEAR);
    wr_addr    = (state_q == S_CLEAR) ? clr_q : it_mol[AW-1:0];
    meta_wdata = (state_q == S_CLEAR || it_q.cls == cdws_pkg::CL_PLACE) ? 11'd0
                                                                     : {ml_q, mf_q};
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[wr_addr] <= {x_q, y_q, z_q};
    pos_rd_q <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[wr_addr] <= meta_wdata;
    meta_rd_q <= meta_mem[rd_addr];
  end

  cdws_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sum_now[63:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  cdws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_abs[63:0]),
    .divisor_i  (r_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hit_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= prod_full[65:0];
      if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MOLECULES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (head_i.valid) begin
            it_q   <= head_i.item;
            hit_q  <= 1'b0;
            done_q <= 1'b0;
            case (head_i.item.cls)
              cdws_pkg::CL_PLACE: state_q <= S_P1;
              cdws_pkg::CL_WALK:  state_q <= S_LOAD;
              default:            state_q <= S_WB;
            endcase
          end
        end
        S_LOAD: begin
          x_q     <= $signed(pos_rd_q[95:64]);
          y_q     <= $signed(pos_rd_q[63:32]);
          z_q     <= $signed(pos_rd_q[31:0]);
          ml_q    <= meta_rd_q[10:1];
          mf_q    <= meta_rd_q[0];
          state_q <= S_SQ1;
        end
        S_SQ1: begin
          acc_q   <= $unsigned(prod_q);
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          acc_q   <= sum_now;
          state_q <= S_SQ3;
        end
        S_SQ3: begin
          if (ml_q == 10'd0) begin
            ml_q <= micro_now ? mm : 10'd1;
            mf_q <= micro_now;
          end
          state_q <= S_STEP;
        end
        S_STEP: begin
          step_q  <= mf_q ? prod_q[50:16] : 35'(it_q.step_mag);
          state_q <= S_CAND;
        end
        S_CAND: begin
          tx_q <= x_q;
          ty_q <= y_q;
          tz_q <= z_q;
          case (it_q.direction)
            DIR_XP:  tx_q <= cdws_pkg::sat32(68'(x_q) + 68'(step_s));
            DIR_XN:  tx_q <= cdws_pkg::sat32(68'(x_q) - 68'(step_s));
            DIR_YP:  ty_q <= cdws_pkg::sat32(68'(y_q) + 68'(step_s));
            DIR_YN:  ty_q <= cdws_pkg::sat32(68'(y_q) - 68'(step_s));
            DIR_ZP:  tz_q <= cdws_pkg::sat32(68'(z_q) + 68'(step_s));
            3'd5:    tz_q <= cdws_pkg::sat32(68'(z_q) - 68'(step_s));
            default: ;
          endcase
          state_q <= S_OR1;
        end
        S_OR1: state_q <= S_OR2;
        S_OR2: begin
          acc_q   <= $unsigned(prod_q);
          state_q <= S_OR3;
        end
        S_OR3: begin
          if (open_ok && wall_ok) begin
            x_q <= tx_q;
            y_q <= ty_q;
            z_q <= tz_q;
          end
          state_q <= S_ZONE;
        end
        S_ZONE: begin
          zb_q <= 1'b0;
          if (z_q > cap_h) begin
            zr_q    <= 33'(z_q) - 33'(cap_h);
            state_q <= S_A1;
          end else if (z_q >= v_bot) begin
            z_q     <= cdws_pkg::sat32(68'(z_q) + 68'($signed(cfg_i.dab[63:32])));
            zb_q    <= 1'b1;
            state_q <= S_XY1;
          end else begin
            z_q     <= cdws_pkg::sat32(68'(z_q) + 68'($signed(cfg_i.dc[63:32])));
            state_q <= S_XY1;
          end
        end
        S_A1: begin
          acc_q   <= $unsigned(prod_q);
          state_q <= S_A2;
        end
        S_A2: begin
          acc_q   <= sum_now;
          state_q <= S_A3;
        end
        S_A3: state_q <= (sum_now[65:64] == 2'b00) ? S_ROOT : S_XY1;
        S_ROOT: begin
          if (sq_done) begin
            r_q   <= sq_root;
            crd_q <= 2'd0;
            if (sq_root != 32'd0 && sq_root < cfg_i.vbot[63:32]) state_q <= S_AMUL;
            else state_q <= S_XY1;
          end
        end
        S_AMUL: state_q <= S_DSTART;
        S_DSTART: begin
          neg_q   <= prod_q[65];
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            case (crd_q)
              2'd0:    dx_q <= d_new;
              2'd1:    dy_q <= d_new;
              default: dz_q <= d_new;
            endcase
            if (crd_q == 2'd2) begin
              state_q <= S_AFIN;
            end else begin
              crd_q   <= crd_q + 2'd1;
              state_q <= S_AMUL;
            end
          end
        end
        S_AFIN: begin
          if (nz < cap_h) begin
            x_q <= '0;
            y_q <= '0;
            z_q <= cap_h;
          end else begin
            x_q <= nx;
            y_q <= ny;
            z_q <= nz;
          end
          state_q <= S_XY1;
        end
        S_XY1: state_q <= S_XY2;
        S_XY2: begin
          acc_q   <= $unsigned(prod_q);
          state_q <= S_XY3;
        end
        S_XY3: begin
          xy2_q <= sum_now;
          if (zb_q && z_q < v_bot && sum_now > ch_r2) z_q <= v_bot;
          state_q <= S_FIN;
        end
        S_FIN: begin
          hit_q <= hit_now;
          if (hit_now) begin
            ml_q        <= 10'd0;
            done_q      <= 1'b1;
            hit_total_q <= hit_total_q + 32'd1;
            state_q     <= S_R1;
          end else begin
            ml_q    <= ml_q - 10'd1;
            done_q  <= (ml_q == 10'd1);
            state_q <= S_WB;
          end
        end
        S_R1: state_q <= S_R2;
        S_R2: begin
          if (it_q.edge_coin) begin
            x_q <= cent_now;
            y_q <= neg_s32;
          end else begin
            x_q <= neg_s32;
            y_q <= cent_now;
          end
          state_q <= S_R3;
        end
        S_R3: begin
          z_q     <= hgt_now;
          state_q <= S_WB;
        end
        S_P1: state_q <= S_P2;
        S_P2: begin
          x_q     <= cent_now;
          state_q <= S_P3;
        end
        S_P3: begin
          y_q     <= cent_now;
          state_q <= S_P4;
        end
        S_P4: begin
          z_q     <= hgt_now;
          state_q <= S_P5;
        end
        S_P5: begin
          acc_q   <= $unsigned(prod_q);
          state_q <= S_P6;
        end
        S_P6: begin
          if (z_q < cap_h && sum_now < cap_r2) begin
            z_q <= cdws_pkg::sat32(68'(z_q) + 68'(cap_h));
          end
          state_q <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_done_q  <= done_q;
            out_micro_q <= (it_q.cls == cdws_pkg::CL_WALK) && mf_q;
            out_total_q <= hit_total_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign step_done_o  = out_done_q;
  assign micro_mode_o = out_micro_q;
  assign total_hits_o = out_total_q;

`ifndef ASSERT_OFF
  a_root_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_ROOT) else $error("root result outside wait state");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DWAIT) else $error("quotient outside wait state");

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && hit_now) |=> hit_total_q == $past(hit_total_q) + 32'd1)
    else $error("hit not counted");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !pop_o && !pos_we) else $error("item taken during clear");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/channel_diffusion_walk_step_core.sv
// Channel diffusion walk step core: one random-walk move or placement per in-range item.
// Depends on cdws_pkg, cdws_front, cdws_back (which uses cdws_sqrt and cdws_div).
//
// Input channel: in_valid_i / in_stall_o with the item fields; an item is taken
// when valid is high and stall is low. A two-entry queue in front lets items
// arrive while the back end works. Output channel: out_valid_o / out_stall_i,
// one result per item, held in an output register while the receiver stalls.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i.
// Work per item is set by the back-end sequencer and its shared multiplier. A placement
// and a move each run their own state sequence, an out-of-range index goes straight to
// write-back, a hit adds a repositioning of the molecule, and a move above the cap within
// the potential extent adds the root and three divisions.
// Results leave in item order through the output register loaded in the write-back step.
// After reset the per-molecule step counters are cleared, one entry a cycle, over all
// MOLECULES entries; no item leaves the queue until this is done.
// Position entries hold no value until a placement writes them.
`default_nettype none
module channel_diffusion_walk_step_core #(
  parameter int unsigned MOLECULES = cdws_pkg::MOLECULES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cdws_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [63:0]                     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            kind_i,
  input  wire logic [9:0]                      molecule_i,
  input  wire logic [18:0]                     step_mag_i,
  input  wire logic [2:0]                      direction_i,
  input  wire logic                            edge_coin_i,
  input  wire logic [15:0]                     uniform_a_i,
  input  wire logic [15:0]                     uniform_b_i,
  input  wire logic [15:0]                     uniform_c_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 hit_o,
  output logic                                 step_done_o,
  output logic                                 micro_mode_o,
  output logic [31:0]                          total_hits_o
);

  cdws_pkg::cfg_t        cfg_q;
  cdws_pkg::queue_head_t head;
  logic                  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box   <= 31'd1048576;
      cfg_q.cap   <= '0;
      cfg_q.chan  <= '0;
      cfg_q.vest  <= '0;
      cfg_q.vbot  <= '0;
      cfg_q.dab   <= '0;
      cfg_q.dc    <= 64'd65536;
      cfg_q.micro <= 10'd1;
    end else if (cfg_we_i) begin
      unique case (cdws_pkg::cfg_reg_e'(cfg_index_i))
        cdws_pkg::REG_BOX:   cfg_q.box   <= cfg_data_i[30:0];
        cdws_pkg::REG_CAP:   cfg_q.cap   <= cfg_data_i;
        cdws_pkg::REG_CHAN:  cfg_q.chan  <= cfg_data_i;
        cdws_pkg::REG_VEST:  cfg_q.vest  <= cfg_data_i;
        cdws_pkg::REG_VBOT:  cfg_q.vbot  <= cfg_data_i;
        cdws_pkg::REG_DAB:   cfg_q.dab   <= cfg_data_i;
        cdws_pkg::REG_DC:    cfg_q.dc    <= cfg_data_i;
        cdws_pkg::REG_MICRO: cfg_q.micro <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  cdws_front #(.MOLECULES(MOLECULES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .molecule_i  (molecule_i),
    .step_mag_i  (step_mag_i),
    .direction_i (direction_i),
    .edge_coin_i (edge_coin_i),
    .uniform_a_i (uniform_a_i),
    .uniform_b_i (uniform_b_i),
    .uniform_c_i (uniform_c_i),
    .head_o      (head),
    .pop_i       (pop)
  );

  cdws_back #(.MOLECULES(MOLECULES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .step_done_o  (step_done_o),
    .micro_mode_o (micro_mode_o),
    .total_hits_o (total_hits_o)
  );

endmodule
`default_nettype wire
